// ===== design/bic_pkg.sv =====
package bic_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_HEIGHT  = 2048;
    localparam int FRAC_BITS   = 8;

    localparam int REG_W       = 12;
    localparam int CNT_W       = 11;
    localparam int SUM_W       = 33;
    localparam int TALLY_W     = 23;
    localparam int CENTER_W    = 19;
    localparam int PIXEL_W     = 8;
    localparam int CFG_IDX_W   = 2;

    localparam int DIVIDEND_W  = SUM_W + FRAC_BITS;
    localparam int STEP_W      = $clog2(DIVIDEND_W);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    localparam logic [REG_W-1:0] WIDTH_RESET  = REG_W'(640);
    localparam logic [REG_W-1:0] HEIGHT_RESET = REG_W'(480);

    // Frame totals handed from the accumulator to the divider
    typedef struct packed {
        logic [SUM_W-1:0]   sum_x;
        logic [SUM_W-1:0]   sum_y;
        logic [TALLY_W-1:0] tally;
    } t_frame;

    function automatic logic [REG_W-1:0] clamp_size(input logic [REG_W-1:0] v,
                                                     input logic [REG_W-1:0] maxv);
        logic [REG_W-1:0] r;
        if (v == '0) begin
            r = REG_W'(1);
        end else if (v > maxv) begin
            r = maxv;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== design/bic_front.sv =====
module bic_front import bic_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [PIXEL_W-1:0] i_pixel_value,
    input  logic [REG_W-1:0]   i_width,
    input  logic [REG_W-1:0]   i_height,
    output logic               o_push,
    input  logic               i_push_ready,
    output t_frame             o_frame
);

    logic [CNT_W-1:0]   r_col, n_col;
    logic [CNT_W-1:0]   r_row, n_row;
    logic [SUM_W-1:0]   r_sum_x, n_sum_x;
    logic [SUM_W-1:0]   r_sum_y, n_sum_y;
    logic [TALLY_W-1:0] r_tally, n_tally;

    logic [REG_W-1:0] w_lim, h_lim;
    logic             row_end, frame_end, pix_set, accept;

    always_comb begin
        w_lim     = clamp_size(i_width, REG_W'(MAX_WIDTH));
        h_lim     = clamp_size(i_height, REG_W'(MAX_HEIGHT));
        row_end   = ({1'b0, r_col} + REG_W'(1)) >= w_lim;
        frame_end = row_end && (({1'b0, r_row} + REG_W'(1)) >= h_lim);
        pix_set   = i_pixel_value != '0;
        accept    = i_valid && o_ready;
    end

    // stall only when a frame end finds the queue full
    assign o_ready = !frame_end || i_push_ready;
    assign o_push  = i_valid && frame_end;

    always_comb begin
        n_sum_x = r_sum_x + (pix_set ? SUM_W'(r_col) : '0);
        n_sum_y = r_sum_y + (pix_set ? SUM_W'(r_row) : '0);
        n_tally = r_tally + (pix_set ? TALLY_W'(1) : '0);
        n_col   = r_col + CNT_W'(1);
        n_row   = r_row;
        if (row_end) begin
            n_col = '0;
            n_row = r_row + CNT_W'(1);
        end
    end

    assign o_frame = '{sum_x: n_sum_x, sum_y: n_sum_y, tally: n_tally};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_sum_x <= '0;
            r_sum_y <= '0;
            r_tally <= '0;
        end else if (accept) begin
            if (frame_end) begin
                r_col   <= '0;
                r_row   <= '0;
                r_sum_x <= '0;
                r_sum_y <= '0;
                r_tally <= '0;
            end else begin
                r_col   <= n_col;
                r_row   <= n_row;
                r_sum_x <= n_sum_x;
                r_sum_y <= n_sum_y;
                r_tally <= n_tally;
            end
        end
    end

endmodule

// ===== design/bic_queue.sv =====
module bic_queue import bic_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    output logic   o_push_ready,
    input  t_frame i_frame,
    output logic   o_pop_valid,
    input  logic   i_pop,
    output t_frame o_frame
);

    t_frame              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr, r_rd;
    logic [QCNT_W-1:0]   r_cnt;
    logic                do_push, do_pop;

    assign o_push_ready = r_cnt != QCNT_W'(QUEUE_DEPTH);
    assign o_pop_valid  = r_cnt != '0;
    assign o_frame      = r_mem[r_rd];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + QCNT_W'(1);
                2'b01:   r_cnt <= r_cnt - QCNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== design/bic_divider.sv =====
module bic_divider import bic_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_frame_valid,
    output logic                o_pop,
    input  t_frame              i_frame,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [CENTER_W-1:0] o_center_x,
    output logic [CENTER_W-1:0] o_center_y,
    output logic [TALLY_W-1:0]  o_set_pixel_count,
    output logic                o_any_set
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]            r_state;
    logic [STEP_W-1:0]     r_step;
    logic [DIVIDEND_W-1:0] r_dx, r_dy;
    logic [TALLY_W-1:0]    r_remx, r_remy;
    logic [TALLY_W-1:0]    r_div;
    logic                  r_out_valid;
    logic [CENTER_W-1:0]   r_cx, r_cy;
    logic [TALLY_W-1:0]    r_cnt;
    logic                  r_any;

    logic [TALLY_W:0]      tx, ty;
    logic                  qx, qy, out_free;

    // one restoring step per cycle on both axes
    always_comb begin
        tx = {r_remx, r_dx[DIVIDEND_W-1]};
        ty = {r_remy, r_dy[DIVIDEND_W-1]};
        qx = tx >= {1'b0, r_div};
        qy = ty >= {1'b0, r_div};
    end

    assign out_free = !r_out_valid || i_ready;
    assign o_pop    = (r_state == S_IDLE) && i_frame_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_frame_valid) begin
                        r_state <= S_RUN;
                        r_step  <= '0;
                    end
                end
                S_RUN: begin
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(DIVIDEND_W - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_frame_valid) begin
            r_dx   <= {i_frame.sum_x, FRAC_BITS'(0)};
            r_dy   <= {i_frame.sum_y, FRAC_BITS'(0)};
            r_remx <= '0;
            r_remy <= '0;
            r_div  <= i_frame.tally;
        end else if (r_state == S_RUN) begin
            r_remx <= qx ? TALLY_W'(tx - {1'b0, r_div}) : tx[TALLY_W-1:0];
            r_remy <= qy ? TALLY_W'(ty - {1'b0, r_div}) : ty[TALLY_W-1:0];
            r_dx   <= {r_dx[DIVIDEND_W-2:0], qx};
            r_dy   <= {r_dy[DIVIDEND_W-2:0], qy};
        end
    end

    // empty frame reports centre zero
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_any <= r_div != '0;
            r_cnt <= r_div;
            r_cx  <= (r_div != '0) ? r_dx[CENTER_W-1:0] : '0;
            r_cy  <= (r_div != '0) ? r_dy[CENTER_W-1:0] : '0;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_center_x        = r_cx;
    assign o_center_y        = r_cy;
    assign o_set_pixel_count = r_cnt;
    assign o_any_set         = r_any;

endmodule

// ===== design/binary_image_centroid.sv =====
// Pixels: one per cycle; the input stalls only at a frame end while the two-entry
// frame queue is full.
// Path: a frame's totals pass the queue hop, 41 steps of the restoring divider and the
// output register; the divider takes the next frame only after the last result is registered.
// Reset: width 640, height 480, raster counters and sums cleared, queue and output empty.
module binary_image_centroid import bic_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [PIXEL_W-1:0]   i_pixel_value,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [CENTER_W-1:0]  o_center_x,
    output logic [CENTER_W-1:0]  o_center_y,
    output logic [TALLY_W-1:0]   o_set_pixel_count,
    output logic                 o_any_set,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [REG_W-1:0]     i_cfg_data
);

    logic [REG_W-1:0] r_width, r_height;
    logic             push, push_ready, pop_valid, pop;
    t_frame           push_frame, pop_frame;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                REG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    bic_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_pixel_value (i_pixel_value),
        .i_width       (r_width),
        .i_height      (r_height),
        .o_push        (push),
        .i_push_ready  (push_ready),
        .o_frame       (push_frame)
    );

    bic_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_push_ready (push_ready),
        .i_frame      (push_frame),
        .o_pop_valid  (pop_valid),
        .i_pop        (pop),
        .o_frame      (pop_frame)
    );

    bic_divider u_divider (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_frame_valid     (pop_valid),
        .o_pop             (pop),
        .i_frame           (pop_frame),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_center_x        (o_center_x),
        .o_center_y        (o_center_y),
        .o_set_pixel_count (o_set_pixel_count),
        .o_any_set         (o_any_set)
    );

    a_any_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_any_set == (o_set_pixel_count != '0)))
        else $error("any_set disagrees with pixel count");

    a_empty_center_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_any_set) |-> (o_center_x == '0 && o_center_y == '0))
        else $error("empty frame with nonzero centre");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> !push_ready)
        else $error("input stalled while queue has room");

    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> pop_valid)
        else $error("divider took a frame from an empty queue");

endmodule
